/* src/mwsl_pkg.sv */
package mwsl_pkg;

    // Default sizing, used as the defaults of the top level parameters
    localparam int DEF_WINDOW_DEPTH = 1024;
    localparam int DEF_VALUE_BITS   = 20;

    // Threshold register
    localparam int TARGET_BITS  = 30;
    localparam int TARGET_RESET = 1;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DROP,
        BK_CHECK,
        BK_POP
    } back_state_t;

    // Control side of the queue head, front to back
    typedef struct packed {
        logic valid;
        logic last;
    } q_ctrl_t;

endpackage

/* src/mwsl_in_if.sv */
interface mwsl_in_if #(parameter int VALUE_BITS = 20);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

/* src/mwsl_out_if.sv */
interface mwsl_out_if #(parameter int LEN_BITS = 11);
    logic                valid;
    logic                ready;
    logic [LEN_BITS-1:0] min_length;
    logic                window_overflow;

    modport source (output valid, output min_length, output window_overflow, input ready);
    modport sink   (input valid, input min_length, input window_overflow, output ready);
endinterface

/* src/mwsl_cfg_if.sv */
interface mwsl_cfg_if import mwsl_pkg::*; #(parameter int DATA_BITS = TARGET_BITS);
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/mwsl_ram.sv */
module mwsl_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/mwsl_front.sv */
module mwsl_front import mwsl_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mwsl_in_if.sink               item,
    output q_ctrl_t               q_ctrl,
    output logic [VALUE_BITS-1:0] q_value,
    input  logic                  q_ready
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0] value_q [QUEUE_DEPTH];
    logic                  last_q  [QUEUE_DEPTH];

    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;

    logic push, pop;

    function automatic logic [QP_W-1:0] qp_inc(input logic [QP_W-1:0] p);
        return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign item.ready   = (count_reg != QC_W'(QUEUE_DEPTH));
    assign push         = item.valid && item.ready;
    assign q_ctrl.valid = (count_reg != '0);
    assign q_ctrl.last  = last_q[rd_ptr_reg];
    assign q_value      = value_q[rd_ptr_reg];
    assign pop          = q_ctrl.valid && q_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? qp_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? qp_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Request payload store, tagged with its end-of-sequence mark
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_q[wr_ptr_reg] <= item.value;
            last_q[wr_ptr_reg]  <= item.last_item;
        end
    end

endmodule

/* src/mwsl_back.sv */
module mwsl_back import mwsl_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  q_ctrl_t                q_ctrl,
    input  logic [VALUE_BITS-1:0]  q_value,
    output logic                   q_ready,
    input  logic [TARGET_BITS-1:0] target_sum,
    mwsl_out_if.source             result
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = VALUE_BITS + LEN_W;
    localparam int CMP_W = (SUM_W > TARGET_BITS) ? SUM_W : TARGET_BITS;

    back_state_t state_reg, state_next;

    logic [PTR_W-1:0]      oldest_reg, oldest_next;
    logic [PTR_W-1:0]      newest_reg, newest_next;
    logic [LEN_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [LEN_W-1:0]      best_reg, best_next;
    logic                  ovf_reg, ovf_next;
    logic                  last_reg, last_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic                  out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  sum_ge;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Window store: written at the newest slot, read at the oldest
    mwsl_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (newest_reg),
        .wdata (ram_wdata),
        .raddr (oldest_reg),
        .rdata (rd_data)
    );

    assign sum_ge = (CMP_W'(sum_reg) >= CMP_W'(target_sum));

    assign result.valid           = out_valid_reg;
    assign result.min_length      = out_len_reg;
    assign result.window_overflow = out_ovf_reg;

    // Sequencer: push (or drop and push when full), then shrink one element per check and pop
    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        ram_wdata      = value_reg;
        q_ready        = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_ctrl.valid)
                begin
                    last_next  = q_ctrl.last;
                    value_next = q_value;
                    if (count_reg == LEN_W'(WINDOW_DEPTH))
                    begin
                        // store full: oldest value is being read out
                        state_next = BK_DROP;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = q_value;
                        newest_next = ptr_inc(newest_reg);
                        count_next  = count_reg + 1'b1;
                        sum_next    = sum_reg + SUM_W'(q_value);
                        state_next  = BK_CHECK;
                    end
                end
            end

            BK_DROP:
            begin
                // drop oldest and push new into the same slot
                ram_we      = 1'b1;
                sum_next    = sum_reg - SUM_W'(rd_data) + SUM_W'(value_reg);
                oldest_next = ptr_inc(oldest_reg);
                newest_next = ptr_inc(newest_reg);
                ovf_next    = 1'b1;
                state_next  = BK_CHECK;
            end

            BK_CHECK:
            begin
                if ((count_reg != '0) && sum_ge)
                begin
                    if ((best_reg == '0) || (count_reg < best_reg))
                    begin
                        best_next = count_reg;
                    end
                    state_next = BK_POP;
                end
                else if (last_reg)
                begin
                    // hold here until the result register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_next = 1'b1;
                        out_len_next   = best_reg;
                        out_ovf_next   = ovf_reg;
                        oldest_next    = '0;
                        newest_next    = '0;
                        count_next     = '0;
                        sum_next       = '0;
                        best_next      = '0;
                        ovf_next       = 1'b0;
                        state_next     = BK_IDLE;
                    end
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end

            BK_POP:
            begin
                sum_next    = sum_reg - SUM_W'(rd_data);
                oldest_next = ptr_inc(oldest_reg);
                count_next  = count_reg - 1'b1;
                state_next  = BK_CHECK;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule

/* src/min_window_sum_length.sv */
// Channel   Dir  Payload                            Request taken when
// item      in   value, last_item                   item.valid && item.ready
// result    out  min_length, window_overflow        result.valid && result.ready
// cfg       in   data (target_sum)                  cfg.valid && cfg.ready
//
// An item passes a push step, then a window check, plus a pop step and a
// further check for every element the window sheds, plus a drop step when
// the store is full; each pop waits on the registered read of the store.
// Reset: asynchronous, active low; window empties, target_sum returns to 1.
// A two-entry queue takes up to two requests while the back end works or a
// result waits on result.ready; item.ready drops while the queue is full.
// A last item holds the back end until the result register is free.
module min_window_sum_length import mwsl_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    mwsl_in_if.sink    item,
    mwsl_out_if.source result,
    mwsl_cfg_if.sink   cfg
);

    localparam int LEN_BITS = $clog2(WINDOW_DEPTH + 1);

    logic [TARGET_BITS-1:0] target_reg;
    q_ctrl_t                q_ctrl;
    logic [VALUE_BITS-1:0]  q_value;
    logic                   q_ready;

    // Threshold register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_BITS'(TARGET_RESET);
        end
        else if (cfg.valid)
        begin
            target_reg <= cfg.data;
        end
    end

    mwsl_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_ctrl  (q_ctrl),
        .q_value (q_value),
        .q_ready (q_ready)
    );

    mwsl_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .VALUE_BITS   (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ctrl     (q_ctrl),
        .q_value    (q_value),
        .q_ready    (q_ready),
        .target_sum (target_reg),
        .result     (result)
    );

endmodule

/* src/mwsl_checker.sv */
module mwsl_checker #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int LEN_BITS     = 11
) (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                item_last,
    input logic                res_valid,
    input logic                res_ready,
    input logic [LEN_BITS-1:0] res_len,
    input logic                res_ovf
);

    // Last items taken but not yet answered
    logic [3:0] pending_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = item_valid && item_ready && item_last;
    assign res_out = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {3'b000, last_in} - {3'b000, res_out};
        end
    end

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_len) && $stable(res_ovf))
        else $error("result changed while stalled");

    // Every result answers an accepted last item
    a_res_owed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 4'd0)
        else $error("result without a pending last item");

    // Queue, back end and result register hold at most four sequences
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many sequences in flight");

    // A window is never longer than the store
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_len <= LEN_BITS'(WINDOW_DEPTH))
        else $error("min_length beyond window depth");

endmodule

bind min_window_sum_length mwsl_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LEN_BITS     (LEN_BITS)
) u_mwsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_last  (item.last_item),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_len    (result.min_length),
    .res_ovf    (result.window_overflow)
);

/* tb/min_window_predict_check.sv */
module min_window_predict_check import mwsl_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    mwsl_in_if          item,
    mwsl_out_if         result,
    mwsl_cfg_if         cfg,
    output int unsigned mismatches,
    output int unsigned awaiting
);

    localparam int PTR_BITS = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS = PTR_BITS + 1;
    localparam int SUM_BITS = VALUE_BITS + PTR_BITS + 1;

    typedef struct packed {
        logic [LEN_BITS-1:0] min_length;
        logic                window_overflow;
    } window_verdict_t;

    // Shadow of the window: circular store, pointers, length and running sum
    logic [VALUE_BITS-1:0]  window_vals [WINDOW_DEPTH];
    logic [PTR_BITS-1:0]    oldest_idx;
    logic [PTR_BITS-1:0]    newest_idx;
    logic [LEN_BITS-1:0]    window_len;
    logic [LEN_BITS-1:0]    shortest_len;
    logic [SUM_BITS-1:0]    window_total;
    logic                   overflowed;
    logic [TARGET_BITS-1:0] target_sum;

    // Verdicts of finished sequences, oldest first
    window_verdict_t verdicts_due [$];
    int unsigned     fail_count;

    function automatic logic [PTR_BITS-1:0] next_idx(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Predict on every item request, compare on every result request
    always @(posedge clk or negedge rst_n)
    begin
        window_verdict_t want;
        if (!rst_n)
        begin
            target_sum   = TARGET_BITS'(TARGET_RESET);
            oldest_idx   = '0;
            newest_idx   = '0;
            window_len   = '0;
            window_total = '0;
            shortest_len = '0;
            overflowed   = 1'b0;
            verdicts_due.delete();
            fail_count   = 0;
            awaiting     <= 0;
            mismatches   <= 0;
        end
        else
        begin
            // result side
            if (result.valid && result.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("unexpected result: min_length=%0d window_overflow=%0b",
                           result.min_length, result.window_overflow);
                    fail_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result.min_length !== want.min_length)
                    begin
                        $error("min_length: expected %0d, got %0d",
                               want.min_length, result.min_length);
                        fail_count++;
                    end
                    if (result.window_overflow !== want.window_overflow)
                    begin
                        $error("window_overflow: expected %0b, got %0b",
                               want.window_overflow, result.window_overflow);
                        fail_count++;
                    end
                end
            end

            // threshold register
            if (cfg.valid && cfg.ready)
                target_sum = cfg.data;

            // item side
            if (item.valid && item.ready)
            begin
                // full store: oldest element leaves without being a candidate
                if (window_len == LEN_BITS'(WINDOW_DEPTH))
                begin
                    window_total = window_total - window_vals[oldest_idx];
                    oldest_idx   = next_idx(oldest_idx);
                    window_len   = window_len - 1'b1;
                    overflowed   = 1'b1;
                end

                window_vals[newest_idx] = item.value;
                newest_idx   = next_idx(newest_idx);
                window_len   = window_len + 1'b1;
                window_total = window_total + item.value;

                // shrink from the oldest end while the target is still met
                while (window_len != 0 && window_total >= target_sum)
                begin
                    if (shortest_len == 0 || window_len < shortest_len)
                        shortest_len = window_len;
                    window_total = window_total - window_vals[oldest_idx];
                    oldest_idx   = next_idx(oldest_idx);
                    window_len   = window_len - 1'b1;
                end

                if (item.last_item)
                begin
                    verdicts_due.push_back('{min_length: shortest_len,
                                             window_overflow: overflowed});
                    oldest_idx   = '0;
                    newest_idx   = '0;
                    window_len   = '0;
                    window_total = '0;
                    shortest_len = '0;
                    overflowed   = 1'b0;
                end
            end

            awaiting   <= verdicts_due.size();
            mismatches <= fail_count;
        end
    end

endmodule

/* tb/min_window_sum_length_test.sv */
module min_window_sum_length_test;
    import mwsl_pkg::*;

    localparam int WINDOW_DEPTH  = DEF_WINDOW_DEPTH;
    localparam int VALUE_BITS    = DEF_VALUE_BITS;
    localparam int LEN_BITS      = $clog2(WINDOW_DEPTH) + 1;
    localparam int ITEM_GOAL     = 1900;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;
    // worst item sheds a full window (a check and a pop per element) behind a held result
    localparam int QUIET_LIMIT   = 20000;

    localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = '1;
    localparam logic [TARGET_BITS-1:0] TARGET_MAX = '1;

    typedef enum int {
        VALS_FULL,
        VALS_SMALL,
        VALS_HIGH,
        VALS_MIXED
    } value_mix_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned awaiting;

    int items_sent    = 0;
    int seq_count     = 0;
    int target_writes = 0;
    int burst_left    = 0;
    int hold_ask      = 0;
    int hold_served   = 0;

    always #5 clk = ~clk;

    mwsl_in_if  #(.VALUE_BITS(VALUE_BITS)) item_ch ();
    mwsl_out_if #(.LEN_BITS(LEN_BITS))     result_ch ();
    mwsl_cfg_if                            cfg_ch ();

    min_window_sum_length #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    min_window_predict_check #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .VALUE_BITS   (VALUE_BITS)
    ) u_predict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    function automatic logic [VALUE_BITS-1:0] pick_value(input value_mix_t mix);
        value_mix_t m;
        m = (mix == VALS_MIXED) ? value_mix_t'($urandom_range(0, 2)) : mix;
        case (m)
            VALS_SMALL: return VALUE_BITS'($urandom_range(0, 15));
            VALS_HIGH:  return VALUE_MAX - VALUE_BITS'($urandom_range(0, 255));
            default:    return ($urandom_range(0, 19) == 0) ? '0
                               : VALUE_BITS'($urandom_range(1, VALUE_MAX));
        endcase
    endfunction

    // One item request; valid stays high afterwards unless a gap follows
    task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        item_ch.valid     <= 1'b1;
        item_ch.value     <= v;
        item_ch.last_item <= last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_sequence(input int len, input value_mix_t mix);
        for (int i = 0; i < len; i++)
            send_item(pick_value(mix), i == len - 1);
        seq_count++;
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [TARGET_BITS-1:0] t);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        target_writes++;
    endtask

    // Result side: changing stall patterns, plus a long hold on request
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        mode_left = 0;
        mode      = 0;
        tick      = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_ask != hold_served)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles without any accepted request
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no request accepted for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        int                     phase;
        int                     n_seq;
        int                     n_small;
        int                     kind;
        int                     span;
        value_mix_t             mix;
        logic [TARGET_BITS-1:0] tgt;

        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.value     <= '0;
        item_ch.last_item <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // target at its reset value: zero values never reach it
        send_item('0, 1'b1);
        send_item(20'd7, 1'b1);
        send_item('0, 1'b0);
        send_item('0, 1'b1);
        seq_count += 3;

        // target zero: every element is a window of one
        drain();
        write_target('0);
        send_item('0, 1'b0);
        send_item(20'd5, 1'b1);
        seq_count++;

        // unreachable target
        drain();
        write_target(TARGET_MAX);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MAX, 1'b1);
        seq_count++;

        // small target, shrinking down to one element
        drain();
        write_target(TARGET_BITS'(3));
        send_item(20'd1, 1'b0);
        send_item(20'd1, 1'b0);
        send_item(20'd1, 1'b0);
        send_item(20'd3, 1'b1);
        send_item(20'd1, 1'b0);
        send_item(20'd2, 1'b1);
        seq_count += 2;

        // large values with a zero in the middle
        drain();
        write_target(TARGET_BITS'(2500000));
        send_item(VALUE_MAX, 1'b0);
        send_item('0, 1'b0);
        send_item(20'hAAAAA, 1'b0);
        send_item(20'h55555, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MAX, 1'b1);
        seq_count++;

        // random phases, each under its own target
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            drain();
            if (phase == 4)
            begin
                // overrun the window with small values, then close with large ones
                write_target(TARGET_BITS'(3 * VALUE_MAX - $urandom_range(0, 1000)));
                n_small = WINDOW_DEPTH + $urandom_range(1, 40);
                for (int i = 0; i < n_small; i++)
                    send_item(pick_value(VALS_SMALL), 1'b0);
                for (int i = 0; i < 6; i++)
                    send_item(VALUE_MAX, i == 5);
                seq_count++;
            end
            else
            begin
                mix  = value_mix_t'($urandom_range(0, 3));
                kind = $urandom_range(0, 9);
                span = (mix == VALS_SMALL) ? 120 : 8 * int'(VALUE_MAX);
                case (kind)
                    0:       tgt = '0;
                    1:       tgt = TARGET_BITS'(1);
                    2:       tgt = TARGET_MAX;
                    3:       tgt = TARGET_BITS'($urandom_range(0, TARGET_MAX));
                    default: tgt = TARGET_BITS'($urandom_range(1, span));
                endcase
                write_target(tgt);

                if (phase == 2 || $urandom_range(0, 15) == 0)
                begin
                    // results held back while short sequences keep coming
                    hold_ask++;
                    n_seq = $urandom_range(10, 16);
                    repeat (n_seq) send_sequence($urandom_range(1, 3), mix);
                end
                else
                begin
                    n_seq = $urandom_range(3, 8);
                    repeat (n_seq)
                        send_sequence(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 12),
                                      mix);
                end
            end
            phase++;
        end

        drain();
        $display("Run covered %0d items in %0d sequences under %0d target settings,",
                 items_sent, seq_count, target_writes);
        $display("zero and maximum targets, a %0d-entry window overrun and long result stalls.",
                 WINDOW_DEPTH);
        if (mismatches == 0 && awaiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
